/* rtl/asgd_pkg.sv */
// ----------------------------------------------------------------------------
// asgd_pkg
// Types and constants shared by the step and gesture detector modules.
// ----------------------------------------------------------------------------
package asgd_pkg;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CNT_WIDTH       = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_DELTA  = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_WINDOW = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RUN_WINDOW  = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MOVING_THR  = 8'd3;

    localparam logic [15:0] RST_STEP_DELTA  = 16'd4915;
    localparam logic [15:0] RST_STEP_WINDOW = 16'd250;
    localparam logic [15:0] RST_RUN_WINDOW  = 16'd300;
    localparam logic [15:0] RST_MOVING_THR  = 16'd1638;

    localparam logic [15:0]        ONE_G       = 16'd16384;
    localparam logic signed [15:0] WRIST_LEVEL = 16'sd8192;
    localparam logic signed [15:0] FLICK_LEVEL = 16'sd26200;

    // square accumulation: three products, then a final accumulate to drain
    localparam logic [CNT_WIDTH-1:0] MAC_LAST   = 4'd3;
    localparam logic [CNT_WIDTH-1:0] SQRT_LAST  = 4'd15;
    localparam logic [31:0]          SQRT_FIRST = 32'h4000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_SQRT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic [1:0] mul_sel;
        logic       acc;
        logic       sq_step;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

/* rtl/asgd_ctrl.sv */
// ----------------------------------------------------------------------------
// asgd_ctrl
// Sequencer: capture, square accumulation, bit-serial root, result update.
// ----------------------------------------------------------------------------
module asgd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  asgd_pkg::t_status i_status,
    output asgd_pkg::t_cmd   o_cmd
);

    asgd_pkg::t_state r_state, n_state;
    logic [asgd_pkg::CNT_WIDTH-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asgd_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            asgd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = asgd_pkg::S_MAC;
                end
            end
            asgd_pkg::S_MAC: begin
                o_cmd.mul     = (r_cnt != asgd_pkg::MAC_LAST);
                o_cmd.mul_sel = r_cnt[1:0];
                o_cmd.acc     = (r_cnt != '0);
                if (r_cnt == asgd_pkg::MAC_LAST) begin
                    n_cnt   = '0;
                    n_state = asgd_pkg::S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            asgd_pkg::S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                if (r_cnt == asgd_pkg::SQRT_LAST) begin
                    n_cnt   = '0;
                    n_state = asgd_pkg::S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            asgd_pkg::S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = asgd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = asgd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/asgd_dp.sv */
// ----------------------------------------------------------------------------
// asgd_dp
// Datapath: sample capture, shared squarer, root, step state, output register.
// ----------------------------------------------------------------------------
module asgd_dp #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  asgd_pkg::t_cmd                        i_cmd,
    output asgd_pkg::t_status                     o_status,
    input  logic                                  i_cfg_write,
    input  logic [asgd_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [asgd_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    input  logic signed [15:0]                    i_accel_x,
    input  logic signed [15:0]                    i_accel_y,
    input  logic signed [15:0]                    i_accel_z,
    input  logic signed [15:0]                    i_gyro_x,
    input  logic [31:0]                           i_time_ms,
    input  logic                                  i_clear_count,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_step_detected,
    output logic [COUNT_WIDTH-1:0]                o_step_count,
    output logic                                  o_moving,
    output logic                                  o_running,
    output logic                                  o_wrist_raised,
    output logic                                  o_wrist_flicked
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [15:0] r_step_delta, r_step_window, r_run_window, r_moving_thr;

    logic signed [15:0] r_ax, r_ay, r_az, r_gx;
    logic [31:0]        r_time;
    logic               r_clear;

    logic [31:0] r_prod, r_rem, r_root, r_bit;

    logic [15:0]            r_prev_mag;
    logic [31:0]            r_last_ms;
    logic [COUNT_WIDTH-1:0] r_count;

    logic                   r_out_valid;
    logic                   r_o_step, r_o_moving, r_o_running, r_o_raised, r_o_flicked;
    logic [COUNT_WIDTH-1:0] r_o_count;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delta  <= asgd_pkg::RST_STEP_DELTA;
            r_step_window <= asgd_pkg::RST_STEP_WINDOW;
            r_run_window  <= asgd_pkg::RST_RUN_WINDOW;
            r_moving_thr  <= asgd_pkg::RST_MOVING_THR;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                asgd_pkg::CFG_STEP_DELTA:  r_step_delta  <= i_cfg_data;
                asgd_pkg::CFG_STEP_WINDOW: r_step_window <= i_cfg_data;
                asgd_pkg::CFG_RUN_WINDOW:  r_run_window  <= i_cfg_data;
                asgd_pkg::CFG_MOVING_THR:  r_moving_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // squarer
    logic signed [15:0] w_op;
    logic signed [31:0] w_sq;

    always_comb begin
        unique case (i_cmd.mul_sel)
            2'd0:    w_op = r_ax;
            2'd1:    w_op = r_ay;
            default: w_op = r_az;
        endcase
    end

    assign w_sq = 32'(w_op) * 32'(w_op);

    // root step
    logic [31:0] w_trial;
    logic        w_fits;

    assign w_trial = r_root + r_bit;
    assign w_fits  = (r_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax    <= i_accel_x;
            r_ay    <= i_accel_y;
            r_az    <= i_accel_z;
            r_gx    <= i_gyro_x;
            r_time  <= i_time_ms;
            r_clear <= i_clear_count;
            r_rem   <= '0;
            r_root  <= '0;
            r_bit   <= asgd_pkg::SQRT_FIRST;
        end else begin
            if (i_cmd.mul) begin
                r_prod <= w_sq;
            end
            if (i_cmd.acc) begin
                r_rem <= r_rem + r_prod;
            end
            if (i_cmd.sq_step) begin
                if (w_fits) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    // step decision and flags
    logic [15:0]            w_mag, w_delta, w_dev;
    logic [31:0]            w_elapsed, w_run_elapsed;
    logic [COUNT_WIDTH-1:0] w_base, w_count;
    logic                   w_step, w_moving;

    always_comb begin
        w_mag     = r_root[15:0];
        w_delta   = (w_mag > r_prev_mag) ? (w_mag - r_prev_mag) : (r_prev_mag - w_mag);
        w_elapsed = r_time - r_last_ms;
        w_step    = (w_delta > r_step_delta) && (w_elapsed > {16'd0, r_step_window});
        w_base    = r_clear ? '0 : r_count;
        w_count   = (w_step && (w_base != COUNT_MAX)) ? w_base + 1'b1 : w_base;
        w_dev     = (w_mag > asgd_pkg::ONE_G) ? (w_mag - asgd_pkg::ONE_G)
                                              : (asgd_pkg::ONE_G - w_mag);
        w_moving  = (w_dev > r_moving_thr);
        w_run_elapsed = w_step ? 32'd0 : w_elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mag <= asgd_pkg::ONE_G;
            r_last_ms  <= '0;
            r_count    <= '0;
        end else if (i_cmd.finish) begin
            r_prev_mag <= w_mag;
            r_count    <= w_count;
            if (w_step) begin
                r_last_ms <= r_time;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_step    <= w_step;
            r_o_count   <= w_count;
            r_o_moving  <= w_moving;
            r_o_running <= w_moving && (w_run_elapsed < {16'd0, r_run_window});
            r_o_raised  <= (r_az < -asgd_pkg::WRIST_LEVEL) && (r_ay > asgd_pkg::WRIST_LEVEL);
            r_o_flicked <= (r_gx < -asgd_pkg::FLICK_LEVEL) || (r_gx > asgd_pkg::FLICK_LEVEL);
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_step_detected = r_o_step;
    assign o_step_count    = r_o_count;
    assign o_moving        = r_o_moving;
    assign o_running       = r_o_running;
    assign o_wrist_raised  = r_o_raised;
    assign o_wrist_flicked = r_o_flicked;

endmodule

/* rtl/accel_step_and_gesture_detector.sv */
// ----------------------------------------------------------------------------
// accel_step_and_gesture_detector
// One IMU sample in, one step and gesture result out. Each sample goes from
// transfer in to result through capture, squaring and summing the axes on
// one shared multiplier, a bit-serial square root of the sum of squares to
// give the magnitude, and the step state update. A new sample is taken once
// the previous one has left the sequencer; the finished result waits in an
// output register, which holds the sequencer back only if it is still full
// and not being read. Configuration writes are always ready; indexes beyond
// the four registers are ignored.
// ----------------------------------------------------------------------------
module accel_step_and_gesture_detector #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [asgd_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [asgd_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [15:0]                    i_accel_x,
    input  logic signed [15:0]                    i_accel_y,
    input  logic signed [15:0]                    i_accel_z,
    input  logic signed [15:0]                    i_gyro_x,
    input  logic [31:0]                           i_time_ms,
    input  logic                                  i_clear_count,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_step_detected,
    output logic [COUNT_WIDTH-1:0]                o_step_count,
    output logic                                  o_moving,
    output logic                                  o_running,
    output logic                                  o_wrist_raised,
    output logic                                  o_wrist_flicked
);

    asgd_pkg::t_cmd    w_cmd;
    asgd_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    asgd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    asgd_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_write     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .i_gyro_x        (i_gyro_x),
        .i_time_ms       (i_time_ms),
        .i_clear_count   (i_clear_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_step_detected (o_step_detected),
        .o_step_count    (o_step_count),
        .o_moving        (o_moving),
        .o_running       (o_running),
        .o_wrist_raised  (o_wrist_raised),
        .o_wrist_flicked (o_wrist_flicked)
    );

endmodule
